[design/fafr_pkg.sv]
package fafr_pkg;

    // Operation codes carried by an input transfer.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INC   = 2'd2;
    localparam logic [1:0] OP_DEC   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_KIND  = 2'd1;
    localparam logic [1:0] ST_NO_FRAME  = 2'd2;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

    // Frame kinds with special meaning.
    localparam logic [1:0] KIND_BS = 2'd0;
    localparam logic [1:0] KIND_PT = 2'd1;

    localparam int unsigned REF_W = 11;
    localparam logic [REF_W-1:0] REF_MAX = 11'd2047;

    // Per-frame record held in the datapath memory.
    typedef struct packed {
        logic [1:0]       kind;
        logic [REF_W-1:0] refc;
        logic [7:0]       owner;
        logic [19:0]      page;
    } t_meta;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_WRD,
        S_WCHK,
        S_AWR,
        S_APP,
        S_RRD,
        S_RCHK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       scan_inc;
        logic       set_f_scan;
        logic       walk_start;
        logic       walk_evict;
        logic       mem_rd;
        logic       rd_tgt;
        logic       walk_adv;
        logic       unlink;
        logic       set_evict;
        logic       alloc_wr;
        logic       append;
        logic       ref_wr;
        logic       release_tgt;
        logic       set_released;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       tgt_valid;
        logic       scan_free;
        logic       scan_last;
        logic       cur_null;
        logic       match;
        logic       mode_evict;
        logic       kind_pt;
        logic       ref_zero;
        logic       out_free;
    } t_sts;

endpackage

[design/fafr_ifs.sv]
// Request channel.
interface fafr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  frame_index;
    logic [1:0]  frame_kind;
    logic [7:0]  owner_pid;
    logic [19:0] virtual_page;

    modport source (output valid, operation, frame_index, frame_kind, owner_pid,
                    virtual_page, input ready);
    modport sink (input valid, operation, frame_index, frame_kind, owner_pid,
                  virtual_page, output ready);
endinterface

// Response channel.
interface fafr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  granted_frame;
    logic        evicted;
    logic [7:0]  evicted_owner;
    logic [19:0] evicted_page;
    logic        released;

    modport source (output valid, status, granted_frame, evicted, evicted_owner,
                    evicted_page, released, input ready);
    modport sink (input valid, status, granted_frame, evicted, evicted_owner,
                  evicted_page, released, output ready);
endinterface

[design/fafr_datapath.sv]
module fafr_datapath
    import fafr_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_frame_index,
    input  logic [1:0]  i_frame_kind,
    input  logic [7:0]  i_owner_pid,
    input  logic [19:0] i_virtual_page,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_granted_frame,
    output logic        o_evicted,
    output logic [7:0]  o_evicted_owner,
    output logic [19:0] o_evicted_page,
    output logic        o_released
);

    localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int unsigned PW = $clog2(NUM_FRAMES + 1);
    localparam logic [PW-1:0] QNULL = PW'(NUM_FRAMES);

    // Latched request.
    logic [1:0]  r_op;
    logic [5:0]  r_idx;
    logic [1:0]  r_kind_in;
    logic [7:0]  r_pid;
    logic [19:0] r_vp;

    // Frame table and arrival queue state.
    logic [NUM_FRAMES-1:0] r_in_use;
    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_tail;
    t_meta                 meta_mem [NUM_FRAMES];
    logic [PW-1:0]         next_mem [NUM_FRAMES];

    // Walk and scan registers.
    logic [FW-1:0] r_scan;
    logic [FW-1:0] r_f;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_prev;
    logic          r_mode_ev;
    t_meta         r_meta_rd;
    logic [PW-1:0] r_next_rd;

    // Result being built and the output register.
    logic [1:0]  r_res_status;
    logic [5:0]  r_res_granted;
    logic        r_res_ev;
    logic [7:0]  r_res_owner;
    logic [19:0] r_res_page;
    logic        r_res_rel;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [5:0]  r_out_granted;
    logic        r_out_ev;
    logic [7:0]  r_out_owner;
    logic [19:0] r_out_page;
    logic        r_out_rel;

    logic [FW-1:0]    tgt;
    logic [FW-1:0]    rd_addr;
    logic [REF_W-1:0] ref_new;

    assign tgt     = FW'(r_idx);
    assign rd_addr = i_cmd.rd_tgt ? tgt : r_cur[FW-1:0];

    // New reference count: saturating increment or decrement held at zero.
    always_comb begin
        if (r_op == OP_INC) begin
            ref_new = (r_meta_rd.refc < REF_MAX) ? r_meta_rd.refc + 1'b1 : r_meta_rd.refc;
        end else begin
            ref_new = (r_meta_rd.refc != '0) ? r_meta_rd.refc - 1'b1 : '0;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.op         = r_op;
        o_sts.tgt_valid  = (32'(r_idx) < NUM_FRAMES) && r_in_use[tgt];
        o_sts.scan_free  = !r_in_use[r_scan];
        o_sts.scan_last  = (r_scan == FW'(NUM_FRAMES - 1));
        o_sts.cur_null   = (r_cur >= QNULL);
        o_sts.match      = r_mode_ev ? (r_meta_rd.kind == KIND_BS) : (r_cur == PW'(tgt));
        o_sts.mode_evict = r_mode_ev;
        o_sts.kind_pt    = (r_meta_rd.kind == KIND_PT);
        o_sts.ref_zero   = (ref_new == '0);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Control state: occupancy, queue ends and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_head      <= QNULL;
            r_tail      <= QNULL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.release_tgt) begin
                r_in_use[tgt] <= 1'b0;
            end
            if (i_cmd.alloc_wr) begin
                r_in_use[r_f] <= 1'b1;
            end
            if (i_cmd.unlink) begin
                if (r_prev == QNULL) begin
                    r_head <= r_next_rd;
                end
                if (r_tail == r_cur) begin
                    r_tail <= r_prev;
                end
            end
            if (i_cmd.append) begin
                if (r_head >= QNULL) begin
                    r_head <= PW'(r_f);
                end
                r_tail <= PW'(r_f);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op          <= i_operation;
            r_idx         <= i_frame_index;
            r_kind_in     <= i_frame_kind;
            r_pid         <= i_owner_pid;
            r_vp          <= i_virtual_page;
            r_scan        <= '0;
            r_res_status  <= ST_OK;
            r_res_granted <= '0;
            r_res_ev      <= 1'b0;
            r_res_owner   <= '0;
            r_res_page    <= '0;
            r_res_rel     <= 1'b0;
        end
        if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.set_f_scan) begin
            r_f <= r_scan;
        end
        if (i_cmd.walk_start) begin
            r_cur     <= r_head;
            r_prev    <= QNULL;
            r_mode_ev <= i_cmd.walk_evict;
        end
        if (i_cmd.walk_adv) begin
            r_prev <= r_cur;
            r_cur  <= r_next_rd;
        end
        if (i_cmd.set_evict) begin
            r_f         <= r_cur[FW-1:0];
            r_res_ev    <= 1'b1;
            r_res_owner <= r_meta_rd.owner;
            r_res_page  <= r_meta_rd.page;
        end
        if (i_cmd.alloc_wr) begin
            r_res_granted <= 6'(r_f);
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.set_released) begin
            r_res_rel <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_ev      <= r_res_ev;
            r_out_owner   <= r_res_owner;
            r_out_page    <= r_res_page;
            r_out_rel     <= r_res_rel;
        end
    end

    // Frame record memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_meta_rd <= meta_mem[rd_addr];
            r_next_rd <= next_mem[rd_addr];
        end
        if (i_cmd.alloc_wr) begin
            meta_mem[r_f] <= '{kind: r_kind_in, refc: '0, owner: r_pid, page: r_vp};
        end else if (i_cmd.ref_wr) begin
            meta_mem[tgt] <= '{kind: r_meta_rd.kind, refc: ref_new,
                               owner: r_meta_rd.owner, page: r_meta_rd.page};
        end
    end

    // Queue link memory: written by unlink, allocation and append.
    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink && (r_prev < QNULL)) begin
            next_mem[r_prev[FW-1:0]] <= r_next_rd;
        end else if (i_cmd.alloc_wr) begin
            next_mem[r_f] <= QNULL;
        end else if (i_cmd.append && (r_head < QNULL) && (r_tail < QNULL)) begin
            next_mem[r_tail[FW-1:0]] <= PW'(r_f);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_frame = r_out_granted;
    assign o_evicted       = r_out_ev;
    assign o_evicted_owner = r_out_owner;
    assign o_evicted_page  = r_out_page;
    assign o_released      = r_out_rel;

`ifndef NO_ASSERTIONS
    // The queue is empty at both ends or at neither.
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head >= QNULL) == (r_tail >= QNULL))
        else $error("queue head and tail disagree on emptiness");

    // A frame handed out is marked in use.
    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_wr |=> r_in_use[$past(r_f)])
        else $error("allocated frame not marked in use");

    // The walk never reads through a null link.
    a_walk_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_rd && !i_cmd.rd_tgt) |-> (r_cur < QNULL))
        else $error("queue walk read at null link");

    // An eviction takes only a backing-store frame that is in use.
    a_evict_bs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_evict |-> (r_meta_rd.kind == KIND_BS) && r_in_use[r_cur[FW-1:0]])
        else $error("eviction of a frame that is not a backing-store page");
`endif

endmodule

[design/fafr_ctrl.sv]
module fafr_ctrl
    import fafr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_ALLOC) begin
                    n_state = S_SCAN;
                end else if (!i_sts.tgt_valid) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_IN_USE;
                    n_state          = S_DONE;
                end else if (i_sts.op == OP_FREE) begin
                    o_cmd.release_tgt  = 1'b1;
                    o_cmd.set_released = 1'b1;
                    o_cmd.walk_start   = 1'b1;
                    n_state            = S_WRD;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_tgt = 1'b1;
                    n_state      = S_RCHK;
                end
            end
            // First-free search, one frame a cycle.
            S_SCAN: begin
                if (i_sts.scan_free) begin
                    o_cmd.set_f_scan = 1'b1;
                    n_state          = S_AWR;
                end else if (i_sts.scan_last) begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.walk_evict = 1'b1;
                    n_state          = S_WRD;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            // Queue walk: read an entry, then test it.
            S_WRD: begin
                if (i_sts.cur_null) begin
                    if (i_sts.mode_evict) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NO_FRAME;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_sts.match) begin
                    o_cmd.unlink = 1'b1;
                    if (i_sts.mode_evict) begin
                        o_cmd.set_evict = 1'b1;
                        n_state         = S_AWR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WRD;
                end
            end
            S_AWR: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_APP;
            end
            S_APP: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_RRD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_tgt = 1'b1;
                n_state      = S_RCHK;
            end
            // Reference update on a page-table frame.
            S_RCHK: begin
                if (!i_sts.kind_pt) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_BAD_KIND;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.ref_wr = 1'b1;
                    if ((i_sts.op == OP_DEC) && i_sts.ref_zero) begin
                        o_cmd.release_tgt  = 1'b1;
                        o_cmd.set_released = 1'b1;
                        o_cmd.walk_start   = 1'b1;
                        n_state            = S_WRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[design/frame_allocator_fifo_replace_top.sv]
// Physical frame table with first-free allocation and FIFO replacement. Each request
// transfer gives exactly one response transfer, one request at a time. Allocate scans
// from frame 0 for the lowest free frame; with every frame in use it scans all
// NUM_FRAMES frames and then walks the arrival queue entry by entry (memory read, then
// test) up to the oldest backing-store frame. Free and a decrement that releases its
// frame walk the queue to the target in the same way. The block takes a new request
// while the last response still waits in its output register.
module frame_allocator_fifo_replace_top
    import fafr_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fafr_in_if.sink       i_req,
    fafr_out_if.source    o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    fafr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Frame table, queue and result registers.
    fafr_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_req.operation),
        .i_frame_index   (i_req.frame_index),
        .i_frame_kind    (i_req.frame_kind),
        .i_owner_pid     (i_req.owner_pid),
        .i_virtual_page  (i_req.virtual_page),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_granted_frame (o_rsp.granted_frame),
        .o_evicted       (o_rsp.evicted),
        .o_evicted_owner (o_rsp.evicted_owner),
        .o_evicted_page  (o_rsp.evicted_page),
        .o_released      (o_rsp.released)
    );

endmodule

[test/tb_top.sv]
module tb_top;
    import fafr_pkg::*;

    localparam int unsigned FRAMES = 64;
    localparam int unsigned QNIL = FRAMES;

    // Expected response fields.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  granted_frame;
        logic        evicted;
        logic [7:0]  evicted_owner;
        logic [19:0] evicted_page;
        logic        released;
    } t_rsp;

    // Request fields.
    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  frame_index;
        logic [1:0]  frame_kind;
        logic [7:0]  owner_pid;
        logic [19:0] virtual_page;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    fafr_in_if  req_if ();
    fafr_out_if rsp_if ();

    frame_allocator_fifo_replace_top #(.NUM_FRAMES(FRAMES)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow frame table.
    logic        fr_used [FRAMES];
    logic [1:0]  fr_kind [FRAMES];
    logic [10:0] fr_refs [FRAMES];
    logic [7:0]  fr_owner [FRAMES];
    logic [19:0] fr_page [FRAMES];
    int unsigned fr_next [FRAMES];
    int unsigned arr_head;
    int unsigned arr_tail;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   fail_count;
    bit   stim_done;
    int   hold_cycles;

    // Remove a frame from the arrival order.
    function automatic void arrival_unlink(int unsigned f);
        int unsigned prv;
        int unsigned cur;
        int unsigned steps;
        prv = QNIL;
        cur = arr_head;
        steps = 0;
        while (cur < QNIL && steps < FRAMES) begin
            if (cur == f) begin
                if (prv >= QNIL) begin
                    arr_head = fr_next[cur];
                end else begin
                    fr_next[prv] = fr_next[cur];
                end
                if (arr_tail == cur) begin
                    arr_tail = prv;
                end
                fr_next[cur] = QNIL;
                return;
            end
            prv = cur;
            cur = fr_next[cur];
            steps++;
        end
    endfunction

    function automatic void frame_release(int unsigned f);
        fr_used[f] = 1'b0;
        fr_kind[f] = '0;
        fr_refs[f] = '0;
        fr_owner[f] = '0;
        fr_page[f] = '0;
        arrival_unlink(f);
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < FRAMES; i++) begin
            fr_used[i] = 1'b0;
            fr_kind[i] = '0;
            fr_refs[i] = '0;
            fr_owner[i] = '0;
            fr_page[i] = '0;
            fr_next[i] = QNIL;
        end
        arr_head = QNIL;
        arr_tail = QNIL;
    endfunction

    // Work out the response to one request and update the shadow table.
    function automatic t_rsp frame_table_apply(t_req r);
        t_rsp res;
        int unsigned f;
        int unsigned cur;
        int unsigned steps;
        int unsigned idx;
        res = '0;
        idx = r.frame_index;
        if (r.operation == OP_ALLOC) begin
            f = QNIL;
            for (int i = 0; i < FRAMES; i++) begin
                if (!fr_used[i]) begin
                    f = i;
                    break;
                end
            end
            if (f >= QNIL) begin
                cur = arr_head;
                steps = 0;
                while (cur < QNIL && steps < FRAMES) begin
                    if (fr_kind[cur] == KIND_BS) begin
                        f = cur;
                        break;
                    end
                    cur = fr_next[cur];
                    steps++;
                end
                if (f < QNIL) begin
                    res.evicted = 1'b1;
                    res.evicted_owner = fr_owner[f];
                    res.evicted_page = fr_page[f];
                    frame_release(f);
                end
            end
            if (f >= QNIL) begin
                res.status = ST_NO_FRAME;
            end else begin
                fr_used[f] = 1'b1;
                fr_kind[f] = r.frame_kind;
                fr_refs[f] = '0;
                fr_owner[f] = r.owner_pid;
                fr_page[f] = r.virtual_page;
                fr_next[f] = QNIL;
                if (arr_head >= QNIL) begin
                    arr_head = f;
                end else if (arr_tail < QNIL) begin
                    fr_next[arr_tail] = f;
                end
                arr_tail = f;
                res.granted_frame = f[5:0];
            end
        end else if (!fr_used[idx]) begin
            res.status = ST_NOT_IN_USE;
        end else if (r.operation == OP_FREE) begin
            frame_release(idx);
            res.released = 1'b1;
        end else if (fr_kind[idx] != KIND_PT) begin
            res.status = ST_BAD_KIND;
        end else if (r.operation == OP_INC) begin
            if (fr_refs[idx] != REF_MAX) begin
                fr_refs[idx] = fr_refs[idx] + 1'b1;
            end
        end else begin
            if (fr_refs[idx] != 0) begin
                fr_refs[idx] = fr_refs[idx] - 1'b1;
            end
            if (fr_refs[idx] == 0) begin
                frame_release(idx);
                res.released = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_req make_req(logic [1:0] op, logic [5:0] idx, logic [1:0] k,
                                      logic [7:0] pid, logic [19:0] vp);
        t_req r;
        r.operation = op;
        r.frame_index = idx;
        r.frame_kind = k;
        r.owner_pid = pid;
        r.virtual_page = vp;
        return r;
    endfunction

    function automatic t_req random_req(int unsigned bias);
        t_req r;
        r.operation = 2'($urandom_range(0, 3));
        if (bias < 45) begin
            r.operation = OP_ALLOC;
        end
        r.frame_index = 6'($urandom);
        r.frame_kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            r.frame_kind = 2'($urandom_range(0, 1));
        end
        r.owner_pid = 8'($urandom);
        r.virtual_page = 20'($urandom);
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus.
    initial begin
        table_clear();
        fail_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Operations on frames not in use, then corner values.
        pending_reqs.push_back(make_req(OP_FREE, 6'd0, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_INC, 6'd63, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_DEC, 6'd5, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd0, KIND_BS, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd63, KIND_PT, 8'hFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd0, 2'd2, 8'h5A, 20'hA5A5A));
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd0, 2'd3, 8'hA5, 20'h5A5A5));
        pending_reqs.push_back(make_req(OP_INC, 6'd0, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_INC, 6'd2, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_INC, 6'd1, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_DEC, 6'd1, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_DEC, 6'd3, 2'd0, 8'd0, 20'd0));
        // Decrement at zero count releases the frame.
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd0, KIND_PT, 8'h11, 20'h11111));
        pending_reqs.push_back(make_req(OP_DEC, 6'd1, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_FREE, 6'd0, 2'd0, 8'd0, 20'd0));
        pending_reqs.push_back(make_req(OP_FREE, 6'd2, 2'd0, 8'd0, 20'd0));
        // A run of increments on one page table, then a decrement.
        pending_reqs.push_back(make_req(OP_ALLOC, 6'd0, KIND_PT, 8'h22, 20'h22222));
        for (int i = 0; i < 20; i++) begin
            pending_reqs.push_back(make_req(OP_INC, 6'd0, 2'd0, 8'd0, 20'd0));
        end
        pending_reqs.push_back(make_req(OP_DEC, 6'd0, 2'd0, 8'd0, 20'd0));

        // Fill the table, force evictions, then exhaust it with non-evictable frames.
        for (int i = 0; i < 70; i++) begin
            pending_reqs.push_back(make_req(OP_ALLOC, 6'($urandom), 2'($urandom_range(0, 1)),
                                            8'($urandom), 20'($urandom)));
        end
        for (int i = 0; i < 70; i++) begin
            pending_reqs.push_back(make_req(OP_ALLOC, 6'($urandom), 2'($urandom_range(1, 3)),
                                            8'($urandom), 20'($urandom)));
        end

        // Random mix; phases alternate between heavy allocation and release.
        for (int i = 0; i < 470; i++) begin
            if ((i / 100) % 2 == 0) begin
                pending_reqs.push_back(random_req($urandom_range(0, 99)));
            end else begin
                pending_reqs.push_back(random_req($urandom_range(35, 99)));
            end
        end
        stim_done = 1'b1;
    end

    // Driver: takes items from the pending queue with random gaps.
    int   gap_left;
    t_req cur_req;
    bit   req_acc;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left <= $urandom_range(0, 17);
        end else if (req_if.valid && !req_acc) begin
            req_if.valid <= 1'b1;
        end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.operation <= cur_req.operation;
            req_if.frame_index <= cur_req.frame_index;
            req_if.frame_kind <= cur_req.frame_kind;
            req_if.owner_pid <= cur_req.owner_pid;
            req_if.virtual_page <= cur_req.virtual_page;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Predict on every accepted request transfer and flag it for the driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_acc <= 1'b0;
        end else begin
            req_acc <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                expected_rsps.push_back(frame_table_apply(make_req(req_if.operation,
                    req_if.frame_index, req_if.frame_kind, req_if.owner_pid,
                    req_if.virtual_page)));
            end
        end
    end

    // Receiver stall; one long hold-off early in the run.
    int  rsp_count;
    int  stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
            hold_cycles <= 0;
        end else if (rsp_count == 30 && hold_cycles < 600) begin
            rsp_if.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rsp_if.valid && rsp_if.ready) begin
            rsp_if.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: compare each response transfer with the oldest expectation.
    t_rsp got_rsp;
    t_rsp exp_rsp;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_count <= 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            got_rsp.status = rsp_if.status;
            got_rsp.granted_frame = rsp_if.granted_frame;
            got_rsp.evicted = rsp_if.evicted;
            got_rsp.evicted_owner = rsp_if.evicted_owner;
            got_rsp.evicted_page = rsp_if.evicted_page;
            got_rsp.released = rsp_if.released;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got_rsp);
                fail_count++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (got_rsp.status !== exp_rsp.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_rsp.status, got_rsp.status);
                if (got_rsp.granted_frame !== exp_rsp.granted_frame)
                    $display("%0t: granted_frame expected %0d actual %0d", $time,
                             exp_rsp.granted_frame, got_rsp.granted_frame);
                if (got_rsp.evicted !== exp_rsp.evicted)
                    $display("%0t: evicted expected %0d actual %0d", $time,
                             exp_rsp.evicted, got_rsp.evicted);
                if (got_rsp.evicted_owner !== exp_rsp.evicted_owner)
                    $display("%0t: evicted_owner expected %h actual %h", $time,
                             exp_rsp.evicted_owner, got_rsp.evicted_owner);
                if (got_rsp.evicted_page !== exp_rsp.evicted_page)
                    $display("%0t: evicted_page expected %h actual %h", $time,
                             exp_rsp.evicted_page, got_rsp.evicted_page);
                if (got_rsp.released !== exp_rsp.released)
                    $display("%0t: released expected %0d actual %0d", $time,
                             exp_rsp.released, got_rsp.released);
                if (got_rsp !== exp_rsp)
                    fail_count++;
            end
        end
    end

    // End of run once all requests are in and all responses are back.
    initial begin
        @(posedge i_rst_n);
        wait (stim_done && pending_reqs.size() == 0 && !req_if.valid
              && expected_rsps.size() == 0);
        repeat (250) @(posedge i_clk);
        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #12000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
